>>> design/sorted_insert_priority_queue_macros.svh
// Assertion macros for the sorted-insert priority queue.
// Used by the top level only; clock and reset are the module's own ports.
`ifndef SORTED_INSERT_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_INSERT_PRIORITY_QUEUE_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked on every rising clock edge out of reset.
`define SIPQ_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sipq assertion failed");
// Next-cycle implication.
`define SIPQ_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sipq assertion failed");
`else
`define SIPQ_ASSERT_IMP(label, ante, cons)
`define SIPQ_ASSERT_NXT(label, ante, cons)
`endif

`endif

>>> design/sipq_pkg.sv
// Types and constants of the sorted-insert priority queue.
// No dependencies; imported by the top level.
package sipq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int KEY_W       = 32;
   localparam int TAG_W       = 16;
   localparam int COUNT_OUT_W = 5;

   typedef enum logic {
      OP_ENQ = 1'b0,
      OP_DEQ = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STAT_DONE  = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_START,
      FSM_DEQ,
      FSM_ENQ,
      FSM_PUT
   } fsm_type;

   typedef struct packed {
      op_type           op;
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
   } req_word_type;

   typedef struct packed {
      status_type             status;
      logic [KEY_W-1:0]       key_out;
      logic [TAG_W-1:0]       tag_out;
      logic [COUNT_OUT_W-1:0] count;
   } rsp_word_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
   } entry_type;

endpackage

>>> design/sipq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sipq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, registered.
   always_ff @(posedge clock) begin
      rd_data <= mem_ff[rd_addr];
   end

endmodule

>>> design/sorted_insert_priority_queue.sv
// Sorted-insert min priority queue: top level with control and entry RAM.
// Depends on sipq_pkg, sipq_ram and sorted_insert_priority_queue_macros.svh.
//
//  channel  direction  handshake              word
//  req      in         req_valid/req_ready    req_word  (op, key, tag)
//  rsp      out        rsp_valid/rsp_ready    rsp_word  (status, key_out, tag_out, count)
//
// Entries live in a ring inside one RAM, ascending from the head, so a dequeue
// only moves the head. An enqueue walks back from the tail, one RAM read and one
// shifting write per cycle, until the new key finds its place.
// A rejection or an enqueue into an empty queue ends at the start step, a
// dequeue ends at the DEQ step, and any other enqueue walks one step per stored
// entry with a larger key, paced by the RAM's registered read.
// Reset (synchronous) empties the queue; RAM contents are not cleared.
// A stalled result holds the block at its final step; one finished word may wait
// in the output register while the next request is taken.
`include "sorted_insert_priority_queue_macros.svh"

module sorted_insert_priority_queue
   import sipq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word
);

   fsm_type          state_ff, state_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   req_word_type     req_ff, req_in;
   rsp_word_type     rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr;
   entry_type        ram_wr_data;
   logic [IDX_W-1:0] ram_rd_addr;
   entry_type        ram_rd_data;
   logic             out_free;
   entry_type        new_entry;

   // Map a position counted from the head onto a RAM address in the ring.
   function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                             input logic [IDX_W-1:0] lidx);
      logic [IDX_W:0] sum;
      sum = {1'b0, head} + {1'b0, lidx};
      if (sum >= (IDX_W+1)'(QUEUE_DEPTH)) begin
         sum = sum - (IDX_W+1)'(QUEUE_DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   // Entry storage.
   sipq_ram #(
      .WIDTH($bits(entry_type)),
      .DEPTH(QUEUE_DEPTH)
   ) u_entry_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign req_ready = (state_ff == FSM_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign new_entry = '{key: req_ff.key, tag: req_ff.tag};

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   // Next state, RAM accesses and result formation.
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = phys(head_ff, pos_ff);
      ram_wr_data  = new_entry;
      ram_rd_addr  = phys(head_ff, '0);

      unique case (state_ff)
         FSM_IDLE: begin
            if (req_valid) begin
               req_in   = req_word;
               state_in = FSM_START;
            end
         end

         FSM_START: begin
            if (req_ff.op == OP_DEQ) begin
               if (count_ff == '0) begin
                  // Dequeue from an empty queue is rejected.
                  if (out_free) begin
                     rsp_in       = '{STAT_EMPTY, '0, '0, COUNT_OUT_W'(count_ff)};
                     rsp_valid_in = 1'b1;
                     state_in     = FSM_IDLE;
                  end
               end else begin
                  // Head entry is being read; it arrives next cycle.
                  state_in = FSM_DEQ;
               end
            end else begin
               if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
                  // Enqueue into a full queue is rejected.
                  if (out_free) begin
                     rsp_in       = '{STAT_FULL, '0, '0, COUNT_OUT_W'(count_ff)};
                     rsp_valid_in = 1'b1;
                     state_in     = FSM_IDLE;
                  end
               end else if (count_ff == '0) begin
                  // Empty queue: the new entry goes straight to the head.
                  if (out_free) begin
                     ram_wr_en    = 1'b1;
                     ram_wr_addr  = phys(head_ff, '0);
                     count_in     = count_ff + CNT_W'(1);
                     rsp_in       = '{STAT_DONE, '0, '0, COUNT_OUT_W'(count_in)};
                     rsp_valid_in = 1'b1;
                     state_in     = FSM_IDLE;
                  end
               end else begin
                  // Start the walk at the tail.
                  ram_rd_addr = phys(head_ff, IDX_W'(count_ff - CNT_W'(1)));
                  pos_in      = IDX_W'(count_ff);
                  state_in    = FSM_ENQ;
               end
            end
         end

         FSM_DEQ: begin
            // Return the head entry and advance the ring.
            if (out_free) begin
               count_in     = count_ff - CNT_W'(1);
               head_in      = (head_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : head_ff + IDX_W'(1);
               rsp_in       = '{STAT_DONE, ram_rd_data.key, ram_rd_data.tag,
                                COUNT_OUT_W'(count_in)};
               rsp_valid_in = 1'b1;
               state_in     = FSM_IDLE;
            end
         end

         FSM_ENQ: begin
            // ram_rd_data holds the entry just below pos_ff.
            if (req_ff.key < ram_rd_data.key) begin
               // Larger key moves up one place; keep walking down.
               ram_wr_en   = 1'b1;
               ram_wr_data = ram_rd_data;
               pos_in      = pos_ff - IDX_W'(1);
               if (pos_ff == IDX_W'(1)) begin
                  state_in = FSM_PUT;
               end else begin
                  ram_rd_addr = phys(head_ff, pos_ff - IDX_W'(2));
               end
            end else begin
               // Keep the read steady in case the result side stalls.
               ram_rd_addr = phys(head_ff, pos_ff - IDX_W'(1));
               if (out_free) begin
                  ram_wr_en    = 1'b1;
                  count_in     = count_ff + CNT_W'(1);
                  rsp_in       = '{STAT_DONE, '0, '0, COUNT_OUT_W'(count_in)};
                  rsp_valid_in = 1'b1;
                  state_in     = FSM_IDLE;
               end
            end
         end

         FSM_PUT: begin
            // New key is the smallest: it lands at the head.
            if (out_free) begin
               ram_wr_en    = 1'b1;
               count_in     = count_ff + CNT_W'(1);
               rsp_in       = '{STAT_DONE, '0, '0, COUNT_OUT_W'(count_in)};
               rsp_valid_in = 1'b1;
               state_in     = FSM_IDLE;
            end
         end

         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   // The queue never holds more than its depth.
   `SIPQ_ASSERT_IMP(a_count_bound, 1'b1, count_ff <= CNT_W'(QUEUE_DEPTH))
   // Every change of occupancy comes with a new result in the output register.
   `SIPQ_ASSERT_IMP(a_count_with_rsp, count_ff != $past(count_ff), rsp_valid_ff)
   // Only a completed dequeue moves the head.
   `SIPQ_ASSERT_IMP(a_head_on_deq, head_ff != $past(head_ff), $past(state_ff) == FSM_DEQ)
   // The RAM is written only on the enqueue path.
   `SIPQ_ASSERT_IMP(a_write_on_enq, ram_wr_en,
                    state_ff == FSM_START || state_ff == FSM_ENQ || state_ff == FSM_PUT)

endmodule

>>> dv/sipq_checker.sv
// Result checker for the sorted-insert priority queue: mirrors the sorted store,
// predicts every result word and compares it with what the block returns.
// Depends on sipq_pkg for the word types, the status codes and the depth.
module sipq_checker
   import sipq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_ready,
   input  req_word_type req_word,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  rsp_word_type rsp_word,
   output int           fail_count,
   output int           pending_count,
   output int           results_seen,
   output int           dequeues_seen,
   output int           full_seen,
   output int           empty_seen
);

   localparam int MAX_PRINTED = 40;

   // Mirror of the queue: ascending keys, entry 0 is the next to leave.
   entry_type    mirror [QUEUE_DEPTH];
   int           held;
   rsp_word_type owed_results [$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
      results_seen  = 0;
      dequeues_seen = 0;
      full_seen     = 0;
      empty_seen    = 0;
      held          = 0;
      foreach (mirror[i]) mirror[i] = '0;
   end

   // Prints one line per mismatch, up to a cap, and counts every one.
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (fail_count < MAX_PRINTED)
         $display("mismatch at result %0d: %s is %0h, expected %0h",
                  results_seen, what, got, want);
      fail_count++;
   endtask

   // Applies one request word to the mirror and returns the result it owes.
   function automatic rsp_word_type apply_to_mirror(input req_word_type w);
      rsp_word_type r;
      int           slot;
      r = '0;
      r.status = STAT_DONE;
      if (w.op == OP_ENQ) begin
         if (held >= QUEUE_DEPTH) begin
            r.status = STAT_FULL;
         end else begin
            // Walk back past strictly larger keys so equal keys keep arrival order.
            slot = held;
            while (slot > 0 && w.key < mirror[slot-1].key) begin
               mirror[slot] = mirror[slot-1];
               slot--;
            end
            mirror[slot].key = w.key;
            mirror[slot].tag = w.tag;
            held++;
         end
      end else if (held == 0) begin
         r.status = STAT_EMPTY;
      end else begin
         r.key_out = mirror[0].key;
         r.tag_out = mirror[0].tag;
         for (int i = 1; i < held; i++) mirror[i-1] = mirror[i];
         held--;
      end
      r.count = COUNT_OUT_W'(held);
      return r;
   endfunction

   // Result words are matched before new requests are predicted, so a stray
   // result can never be paired with a request taken at the same edge.
   always @(posedge clock) begin
      rsp_word_type due;
      if (reset) begin
         held = 0;
         owed_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (owed_results.size() == 0) begin
               report_mismatch("result word with nothing owed, status",
                               rsp_word.status, '0);
            end else begin
               due = owed_results.pop_front();
               if (rsp_word.status !== due.status)
                  report_mismatch("status", rsp_word.status, due.status);
               if (rsp_word.key_out !== due.key_out)
                  report_mismatch("key_out", rsp_word.key_out, due.key_out);
               if (rsp_word.tag_out !== due.tag_out)
                  report_mismatch("tag_out", rsp_word.tag_out, due.tag_out);
               if (rsp_word.count !== due.count)
                  report_mismatch("count", rsp_word.count, due.count);
               if (due.status == STAT_FULL) full_seen++;
               if (due.status == STAT_EMPTY) empty_seen++;
            end
            results_seen++;
         end
         if (req_valid && req_ready) begin
            owed_results.push_back(apply_to_mirror(req_word));
            if (req_word.op == OP_DEQ) dequeues_seen++;
         end
      end
      pending_count <= owed_results.size();
   end

endmodule

>>> dv/tb.sv
// Testbench top for the sorted-insert priority queue: clock, reset, request and
// result traffic with random idling, and the final verdict.
// Depends on sipq_pkg, the block itself and sipq_checker.
module tb
   import sipq_pkg::*;
();

   localparam int CYCLE_LIMIT      = 500000;
   localparam int RANDOM_WORDS     = 1300;
   localparam int LONG_HOLD_AT     = 400;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int CALM_TAIL        = 200;
   localparam int SETTLE_CYCLES    = 40;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_word_type rsp_word;

   int fail_count;
   int pending_count;
   int results_seen;
   int dequeues_seen;
   int full_seen;
   int empty_seen;
   int cycles_run = 0;
   int words_sent = 0;

   bit idle_on       = 1'b1;
   bit long_hold_ask = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   sorted_insert_priority_queue uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   sipq_checker chk (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_word      (req_word),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_word      (rsp_word),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .results_seen  (results_seen),
      .dequeues_seen (dequeues_seen),
      .full_seen     (full_seen),
      .empty_seen    (empty_seen)
   );

   // Watchdog: a hung block ends the run here.
   always @(posedge clock) begin
      cycles_run <= cycles_run + 1;
      if (cycles_run >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d results owed", cycles_run, pending_count);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Offers one request word, sometimes after an idle burst, and holds it until taken.
   task automatic push_word(input req_word_type w);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
   endtask

   task automatic put_pair(input logic [KEY_W-1:0] key, input logic [TAG_W-1:0] tag);
      req_word_type w;
      w.op  = OP_ENQ;
      w.key = key;
      w.tag = tag;
      push_word(w);
   endtask

   task automatic take_min();
      req_word_type w;
      w.op  = OP_DEQ;
      w.key = '0;
      w.tag = '0;
      push_word(w);
   endtask

   // Result side: ready stretches, short stalls, and one long hold-off that
   // backs the block up while requests keep coming.
   initial begin
      bit long_hold_done;
      long_hold_done = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         if (long_hold_ask && !long_hold_done) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            long_hold_done = 1'b1;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   // Request side and verdict.
   initial begin
      req_word_type w;
      bit           enq_lean;
      int           run_left;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_word  = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty dequeue, key and tag extremes, equal keys, fill past full.
      take_min();
      put_pair('0, '0);
      put_pair('1, '1);
      put_pair(32'd5, 16'd1);
      put_pair(32'd5, 16'd2);
      put_pair(32'd5, 16'd3);
      for (int i = 0; i < 11; i++) put_pair(32'd100 - 32'(i * 7), 16'(16'h100 + i));
      put_pair(32'd1, 16'hbeef);
      take_min();
      take_min();

      // Random: runs that lean to enqueue or to dequeue sweep the occupancy
      // between empty and full; small keys give many equal keys.
      enq_lean = 1'b0;
      run_left = 0;
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (run_left == 0) begin
            enq_lean = !enq_lean;
            run_left = $urandom_range(20, 60);
         end
         run_left--;
         if (i == LONG_HOLD_AT) long_hold_ask <= 1'b1;
         if (i == RANDOM_WORDS - CALM_TAIL) idle_on = 1'b0;
         w.op = ($urandom_range(0, 9) < (enq_lean ? 7 : 3)) ? OP_ENQ : OP_DEQ;
         case ($urandom_range(0, 9))
            0, 1, 2, 3: w.key = $urandom_range(0, 7);
            8: w.key = '0;
            9: w.key = '1;
            default: w.key = $urandom;
         endcase
         w.tag = TAG_W'($urandom_range(0, 65535));
         push_word(w);
      end
      req_valid <= 1'b0;

      // Drain every owed result, then watch a while for strays.
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d request words and checked %0d result words in %0d cycles.",
               words_sent, results_seen, cycles_run);
      $display("Dequeue requests: %0d, rejected when full: %0d, rejected when empty: %0d.",
               dequeues_seen, full_seen, empty_seen);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+design
design/sipq_pkg.sv
design/sipq_ram.sv
design/sorted_insert_priority_queue.sv
dv/sipq_checker.sv
dv/tb.sv
